@@ design/fpp_pkg.sv @@
package fpp_pkg;

  // Board geometry
  localparam int BOARD_SQUARES = 64;
  localparam int SQ_W          = 6;
  localparam logic [SQ_W-1:0] SQ_LAST = SQ_W'(BOARD_SQUARES - 1);

  // Queue sizing shared by the input and result queues
  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = 2;
  localparam int Q_CNT_W = 3;

  // Piece codes
  localparam logic [7:0] BLACK_BIT = 8'h80;
  localparam logic [2:0] PT_NONE   = 3'd0;
  localparam logic [2:0] PT_PAWN   = 3'd1;
  localparam logic [2:0] PT_KNIGHT = 3'd2;
  localparam logic [2:0] PT_BISHOP = 3'd3;
  localparam logic [2:0] PT_ROOK   = 3'd4;
  localparam logic [2:0] PT_QUEEN  = 3'd5;
  localparam logic [2:0] PT_KING   = 3'd6;

  // Castling bits
  localparam logic [3:0] CASTLE_WK = 4'h1;
  localparam logic [3:0] CASTLE_WQ = 4'h2;
  localparam logic [3:0] CASTLE_BK = 4'h4;
  localparam logic [3:0] CASTLE_BQ = 4'h8;

  localparam logic [7:0]  NO_EP    = 8'd255;
  localparam logic [15:0] MAX16    = 16'hFFFF;
  localparam logic [3:0]  RANK_TOP = 4'd7;
  localparam logic [3:0]  RANK_OFF = 4'd15;
  localparam logic [4:0]  FILE_SAT = 5'd16;

  // ASCII
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_1     = 8'h31;
  localparam logic [7:0] CH_8     = 8'h38;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UZ    = 8'h5A;
  localparam logic [7:0] CH_UK    = 8'h4B;
  localparam logic [7:0] CH_UQ    = 8'h51;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LB    = 8'h62;
  localparam logic [7:0] CH_LH    = 8'h68;
  localparam logic [7:0] CH_LK    = 8'h6B;
  localparam logic [7:0] CH_LN    = 8'h6E;
  localparam logic [7:0] CH_LP    = 8'h70;
  localparam logic [7:0] CH_LQ    = 8'h71;
  localparam logic [7:0] CH_LR    = 8'h72;
  localparam logic [7:0] CH_LW    = 8'h77;
  localparam logic [7:0] CASE_GAP = 8'd32;

  typedef struct packed {
    logic [7:0] char_code;
    logic       last_char;
  } in_t;

  typedef struct packed {
    logic [5:0]  square_index;
    logic [7:0]  piece_code;
    logic        black_to_play;
    logic [3:0]  castle_flags;
    logic [7:0]  ep_col;
    logic [15:0] half_moves;
    logic [15:0] move_no;
    logic        last_square;
  } out_t;

  // Character as classified by the front end
  typedef struct packed {
    logic       is_space;
    logic       is_slash;
    logic       is_skip;
    logic [3:0] skip_val;
    logic       is_digit;
    logic [3:0] digit_val;
    logic [7:0] piece_code;
    logic       is_w;
    logic [3:0] castle_bit;
    logic       is_ep;
    logic [2:0] ep_file;
    logic       last;
  } cls_t;

  // Header fields carried with each emitted square
  typedef struct packed {
    logic        side;
    logic [3:0]  castle;
    logic [7:0]  ep;
    logic [15:0] half;
    logic [15:0] full;
  } hdr_t;

  typedef enum logic [3:0] {
    PH_PLACE,
    PH_SIDE,
    PH_SKIP1,
    PH_CASTLE,
    PH_EP,
    PH_SKIPSP,
    PH_HALF,
    PH_FULL,
    PH_DONE
  } phase_t;

  typedef enum logic {
    BK_PARSE,
    BK_EMIT
  } back_state_t;

endpackage

@@ design/fen_position_parser.sv @@
// FEN position parser. Characters of a position string are pushed one per
// request; the request flagged last_char closes the string and produces 64
// result requests, squares 0 to 63 in order, each carrying the piece code and
// the header fields (side, castling, en passant file, halfmove clock, fullmove
// number), with last_square set on square 63. The parser consumes one
// character per cycle except while it reads a board out. After the last
// character it reads the board memory out, one square per cycle through its
// single read port while a result queue slot is free. A four-entry
// character queue takes up to four characters of the next string during that
// burst, after which full holds the sender off until the burst ends. A
// four-entry result queue lets the consumer stall without losing squares;
// while it is full the burst pauses. After the burst all parser state is back
// at its reset values for the next string.
module fen_position_parser (
  input  logic          clk,
  input  logic          rst_n,
  // character requests
  input  logic          push,
  output logic          full,
  input  fpp_pkg::in_t  in_data,
  // square result requests
  output logic          empty,
  input  logic          pop,
  output fpp_pkg::out_t out_data
);
  import fpp_pkg::*;

  // front -> back
  logic               deq_valid;
  logic               deq_pop;
  cls_t               deq_data;
  // back -> result queue
  logic [Q_CNT_W-1:0] oq_count;
  logic               oq_push;
  out_t               oq_data;

  // Front end: classifies each character and queues it
  fpp_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .full      (full),
    .in_data   (in_data),
    .deq_valid (deq_valid),
    .deq_pop   (deq_pop),
    .deq_data  (deq_data)
  );

  // Back end: phase machine, board memory and square emission
  fpp_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .deq_valid (deq_valid),
    .deq_pop   (deq_pop),
    .deq_data  (deq_data),
    .oq_count  (oq_count),
    .oq_push   (oq_push),
    .oq_data   (oq_data)
  );

  // Result queue; back end only issues a read when a slot is reserved
  fpp_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (oq_push),
    .push_data (oq_data),
    .count     (oq_count),
    .empty     (empty),
    .pop       (pop),
    .pop_data  (out_data)
  );

endmodule

@@ design/fpp_front.sv @@
module fpp_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  output logic          full,
  input  fpp_pkg::in_t  in_data,
  output logic          deq_valid,
  input  logic          deq_pop,
  output fpp_pkg::cls_t deq_data
);
  import fpp_pkg::*;

  cls_t               cls;
  logic [7:0]         c;
  logic [7:0]         lc;
  logic               upper;
  logic [2:0]         ptype;
  cls_t               q_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [Q_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [Q_CNT_W-1:0] cnt_r, cnt_nxt;
  logic               do_push;
  logic               do_pop;

  // Classify the incoming character
  always_comb begin
    c     = in_data.char_code;
    upper = (c >= CH_UA) && (c <= CH_UZ);
    lc    = upper ? c + CASE_GAP : c;
    case (lc)
      CH_LP:   ptype = PT_PAWN;
      CH_LN:   ptype = PT_KNIGHT;
      CH_LB:   ptype = PT_BISHOP;
      CH_LR:   ptype = PT_ROOK;
      CH_LQ:   ptype = PT_QUEEN;
      CH_LK:   ptype = PT_KING;
      default: ptype = PT_NONE;
    endcase
    cls.is_space   = (c == CH_SPACE);
    cls.is_slash   = (c == CH_SLASH);
    cls.is_skip    = (c >= CH_1) && (c <= CH_8);
    cls.skip_val   = c[3:0];
    cls.is_digit   = (c >= CH_0) && (c <= CH_9);
    cls.digit_val  = c[3:0];
    cls.piece_code = (upper ? 8'h00 : BLACK_BIT) | {5'd0, ptype};
    cls.is_w       = (c == CH_LW);
    case (c)
      CH_UK:   cls.castle_bit = CASTLE_WK;
      CH_UQ:   cls.castle_bit = CASTLE_WQ;
      CH_LK:   cls.castle_bit = CASTLE_BK;
      CH_LQ:   cls.castle_bit = CASTLE_BQ;
      default: cls.castle_bit = 4'h0;
    endcase
    cls.is_ep      = (c >= CH_LA) && (c <= CH_LH);
    cls.ep_file    = 3'(c - CH_LA);
    cls.last       = in_data.last_char;
  end

  assign full      = (cnt_r == Q_CNT_W'(Q_DEPTH));
  assign deq_valid = (cnt_r != '0);
  assign deq_data  = q_r[rd_ptr_r];
  assign do_push   = push && !full;
  assign do_pop    = deq_pop && deq_valid;

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r + Q_CNT_W'(do_push) - Q_CNT_W'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      q_r[wr_ptr_r] <= cls;
    end
  end

endmodule

@@ design/fpp_back.sv @@
module fpp_back (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           deq_valid,
  output logic                           deq_pop,
  input  fpp_pkg::cls_t                  deq_data,
  input  logic [fpp_pkg::Q_CNT_W-1:0]    oq_count,
  output logic                           oq_push,
  output fpp_pkg::out_t                  oq_data
);
  import fpp_pkg::*;

  back_state_t        state_r, state_nxt;
  phase_t             phase_r, phase_nxt;
  logic [3:0]         rank_r, rank_nxt;
  logic [4:0]         file_r, file_nxt;
  logic               side_r, side_nxt;
  logic [3:0]         castle_r, castle_nxt;
  logic [7:0]         ep_r, ep_nxt;
  logic [15:0]        half_r, half_nxt;
  logic [15:0]        full_r, full_nxt;
  logic               seen_r, seen_nxt;
  logic [BOARD_SQUARES-1:0] sq_vld_r, sq_vld_nxt;
  logic [SQ_W-1:0]    emit_idx_r, emit_idx_nxt;

  logic [7:0]         board_mem [BOARD_SQUARES];
  logic               wr_en;
  logic [SQ_W-1:0]    wr_addr;

  logic               s1_vld_r;
  logic [SQ_W-1:0]    s1_idx_r;
  logic [7:0]         s1_data_r;
  logic               s1_bit_r;
  hdr_t               s1_hdr_r;

  logic               take;
  logic               issue;
  logic               emit_end;
  logic [Q_CNT_W:0]   credit_used;
  logic [5:0]         file_sum;
  hdr_t               hdr;

  function automatic logic [15:0] acc_dec(input logic [15:0] acc, input logic [3:0] d);
    logic [19:0] v;
    v = ({4'd0, acc} << 3) + ({4'd0, acc} << 1) + {16'd0, d};
    return (v > {4'd0, MAX16}) ? MAX16 : v[15:0];
  endfunction

  // Controller outputs
  always_comb begin
    credit_used = {1'b0, oq_count} + (Q_CNT_W+1)'(s1_vld_r);
    take        = 1'b0;
    issue       = 1'b0;
    case (state_r)
      BK_PARSE: take  = deq_valid;
      BK_EMIT:  issue = (credit_used < (Q_CNT_W+1)'(Q_DEPTH));
      default:  ;
    endcase
    deq_pop  = take;
    emit_end = issue && (emit_idx_r == SQ_LAST);
  end

  // Controller next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BK_PARSE: if (take && deq_data.last) state_nxt = BK_EMIT;
      BK_EMIT:  if (emit_end) state_nxt = BK_PARSE;
      default:  state_nxt = BK_PARSE;
    endcase
  end

  // Parser datapath
  always_comb begin
    phase_nxt    = phase_r;
    rank_nxt     = rank_r;
    file_nxt     = file_r;
    side_nxt     = side_r;
    castle_nxt   = castle_r;
    ep_nxt       = ep_r;
    half_nxt     = half_r;
    full_nxt     = full_r;
    seen_nxt     = seen_r;
    sq_vld_nxt   = sq_vld_r;
    emit_idx_nxt = issue ? emit_idx_r + 1'b1 : emit_idx_r;
    wr_en        = 1'b0;
    wr_addr      = {rank_r[2:0], file_r[2:0]};
    file_sum     = {1'b0, file_r} + {2'd0, deq_data.skip_val};

    if (take) begin
      case (phase_r)
        PH_PLACE: begin
          if (deq_data.is_space) begin
            phase_nxt = PH_SIDE;
          end else if (deq_data.is_slash) begin
            rank_nxt = (rank_r == 4'd0 || rank_r == RANK_OFF) ? RANK_OFF : rank_r - 1'b1;
            file_nxt = '0;
          end else if (deq_data.is_skip) begin
            file_nxt = (file_sum > {1'b0, FILE_SAT}) ? FILE_SAT : file_sum[4:0];
          end else begin
            // off-board writes are dropped
            if (rank_r <= RANK_TOP && file_r <= 5'd7) begin
              wr_en               = 1'b1;
              sq_vld_nxt[wr_addr] = 1'b1;
            end
            if (file_r < FILE_SAT) file_nxt = file_r + 1'b1;
          end
        end
        PH_SIDE: begin
          side_nxt  = !deq_data.is_w;
          phase_nxt = PH_SKIP1;
        end
        PH_SKIP1: phase_nxt = PH_CASTLE;
        PH_CASTLE: begin
          if (deq_data.is_space) phase_nxt = PH_EP;
          else castle_nxt = castle_r | deq_data.castle_bit;
        end
        PH_EP: begin
          if (deq_data.is_ep) ep_nxt = {5'd0, deq_data.ep_file};
          phase_nxt = deq_data.is_space ? PH_HALF : PH_SKIPSP;
        end
        PH_SKIPSP: if (deq_data.is_space) phase_nxt = PH_HALF;
        PH_HALF: begin
          if (deq_data.is_digit) half_nxt = acc_dec(half_r, deq_data.digit_val);
          else phase_nxt = PH_FULL;
        end
        PH_FULL: begin
          if (deq_data.is_digit) begin
            full_nxt = acc_dec(full_r, deq_data.digit_val);
            seen_nxt = 1'b1;
          end else begin
            phase_nxt = PH_DONE;
          end
        end
        default: ;
      endcase
    end

    // back to reset values once the last square read is issued
    if (emit_end) begin
      phase_nxt  = PH_PLACE;
      rank_nxt   = RANK_TOP;
      file_nxt   = '0;
      side_nxt   = 1'b0;
      castle_nxt = '0;
      ep_nxt     = NO_EP;
      half_nxt   = '0;
      full_nxt   = '0;
      seen_nxt   = 1'b0;
      sq_vld_nxt = '0;
    end
  end

  always_comb begin
    hdr.side   = side_r;
    hdr.castle = castle_r;
    hdr.ep     = ep_r;
    hdr.half   = half_r;
    hdr.full   = seen_r ? full_r : 16'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= BK_PARSE;
      phase_r    <= PH_PLACE;
      rank_r     <= RANK_TOP;
      file_r     <= '0;
      side_r     <= 1'b0;
      castle_r   <= '0;
      ep_r       <= NO_EP;
      half_r     <= '0;
      full_r     <= '0;
      seen_r     <= 1'b0;
      sq_vld_r   <= '0;
      emit_idx_r <= '0;
      s1_vld_r   <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      phase_r    <= phase_nxt;
      rank_r     <= rank_nxt;
      file_r     <= file_nxt;
      side_r     <= side_nxt;
      castle_r   <= castle_nxt;
      ep_r       <= ep_nxt;
      half_r     <= half_nxt;
      full_r     <= full_nxt;
      seen_r     <= seen_nxt;
      sq_vld_r   <= sq_vld_nxt;
      emit_idx_r <= emit_idx_nxt;
      s1_vld_r   <= issue;
    end
  end

  // Board memory: one write, one registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      board_mem[wr_addr] <= deq_data.piece_code;
    end
    if (issue) begin
      s1_data_r <= board_mem[emit_idx_r];
      s1_bit_r  <= sq_vld_r[emit_idx_r];
      s1_idx_r  <= emit_idx_r;
      s1_hdr_r  <= hdr;
    end
  end

  assign oq_push = s1_vld_r;

  always_comb begin
    oq_data.square_index  = s1_idx_r;
    oq_data.piece_code    = s1_bit_r ? s1_data_r : 8'h00;
    oq_data.black_to_play = s1_hdr_r.side;
    oq_data.castle_flags  = s1_hdr_r.castle;
    oq_data.ep_col        = s1_hdr_r.ep;
    oq_data.half_moves    = s1_hdr_r.half;
    oq_data.move_no       = s1_hdr_r.full;
    oq_data.last_square   = (s1_idx_r == SQ_LAST);
  end

endmodule

@@ design/fpp_outq.sv @@
module fpp_outq (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         push,
  input  fpp_pkg::out_t                push_data,
  output logic [fpp_pkg::Q_CNT_W-1:0]  count,
  output logic                         empty,
  input  logic                         pop,
  output fpp_pkg::out_t                pop_data
);
  import fpp_pkg::*;

  out_t               q_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [Q_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [Q_CNT_W-1:0] cnt_r, cnt_nxt;
  logic               do_pop;

  // push is only raised when the producer holds a credit
  assign count    = cnt_r;
  assign empty    = (cnt_r == '0);
  assign pop_data = q_r[rd_ptr_r];
  assign do_pop   = pop && !empty;

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r + Q_CNT_W'(push) - Q_CNT_W'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

@@ tb/sv/tb_top.sv @@
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import fpp_pkg::*;

  // Run length and end-of-run settle time, in clock cycles
  localparam int CYCLE_LIMIT  = 2000000;
  localparam int SETTLE_CYCLES = 200;
  localparam int TARGET_ITEMS = 210;
  localparam int PRINT_CAP    = 40;

  logic  clk = 1'b0;
  logic  rst_n = 1'b0;
  logic  push = 1'b0;
  logic  full;
  in_t   in_data = '0;
  logic  empty;
  logic  pop = 1'b0;
  out_t  out_data;

  fen_position_parser dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .full     (full),
    .in_data  (in_data),
    .empty    (empty),
    .pop      (pop),
    .out_data (out_data)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Pending character requests. A request flagged hold is not presented until
  // every expected square of the earlier strings has come back.
  // ---------------------------------------------------------------------------
  typedef struct {
    in_t req;
    bit  hold;
  } pend_t;

  pend_t      pending_q[$];
  logic [7:0] text_buf[$];
  out_t       board_expect_q[$];
  int         err_cnt = 0;
  int         cycle_cnt = 0;

  // ---------------------------------------------------------------------------
  // Parser model: board, parse position and header fields
  // ---------------------------------------------------------------------------
  logic [7:0]  board_model [BOARD_SQUARES];
  phase_t      parse_ph;
  logic [3:0]  rank_at;
  logic [4:0]  file_at;
  logic        side_bit;
  logic [3:0]  castle_bits;
  logic [7:0]  ep_file;
  logic [15:0] half_clk;
  logic [15:0] full_num;
  logic        full_seen;

  function automatic void clear_parser();
    foreach (board_model[i]) board_model[i] = '0;
    parse_ph    = PH_PLACE;
    rank_at     = RANK_TOP;
    file_at     = '0;
    side_bit    = 1'b0;
    castle_bits = '0;
    ep_file     = NO_EP;
    half_clk    = '0;
    full_num    = '0;
    full_seen   = 1'b0;
  endfunction

  function automatic logic is_dec(logic [7:0] c);
    return c >= CH_0 && c <= CH_9;
  endfunction

  // decimal accumulate, saturating at 16 bits
  function automatic logic [15:0] dec_accum(logic [15:0] acc, logic [7:0] c);
    int v;
    v = int'(acc) * 10 + int'(c) - int'(CH_0);
    return (v > int'(MAX16)) ? MAX16 : 16'(v);
  endfunction

  // Apply one accepted character; the final one queues the 64 squares
  task automatic fen_apply_char(in_t r);
    logic [7:0] c;
    logic [7:0] lc;
    logic [2:0] ptype;
    logic       upper;
    int         f;
    out_t       sq_res;
    c = r.char_code;
    case (parse_ph)
      PH_PLACE: begin
        if (c == CH_SPACE) begin
          parse_ph = PH_SIDE;
        end else if (c == CH_SLASH) begin
          // below rank 0 the rank parks off the board
          rank_at = (rank_at == 0 || rank_at == RANK_OFF) ? RANK_OFF : rank_at - 4'd1;
          file_at = '0;
        end else if (c >= CH_1 && c <= CH_8) begin
          f = int'(file_at) + int'(c) - int'(CH_0);
          file_at = (f > int'(FILE_SAT)) ? FILE_SAT : 5'(f);
        end else begin
          upper = c >= CH_UA && c <= CH_UZ;
          lc    = upper ? c + CASE_GAP : c;
          case (lc)
            CH_LP:   ptype = PT_PAWN;
            CH_LN:   ptype = PT_KNIGHT;
            CH_LB:   ptype = PT_BISHOP;
            CH_LR:   ptype = PT_ROOK;
            CH_LQ:   ptype = PT_QUEEN;
            CH_LK:   ptype = PT_KING;
            default: ptype = PT_NONE;
          endcase
          // off-board writes are dropped, file still advances up to saturation
          if (rank_at <= RANK_TOP && file_at <= 5'd7)
            board_model[{rank_at[2:0], file_at[2:0]}] =
              8'(ptype) | (upper ? 8'h00 : BLACK_BIT);
          if (file_at < FILE_SAT) file_at = file_at + 5'd1;
        end
      end
      PH_SIDE: begin
        side_bit = (c == CH_LW) ? 1'b0 : 1'b1;
        parse_ph = PH_SKIP1;
      end
      PH_SKIP1: parse_ph = PH_CASTLE;
      PH_CASTLE: begin
        if (c == CH_SPACE)   parse_ph = PH_EP;
        else if (c == CH_UK) castle_bits |= CASTLE_WK;
        else if (c == CH_UQ) castle_bits |= CASTLE_WQ;
        else if (c == CH_LK) castle_bits |= CASTLE_BK;
        else if (c == CH_LQ) castle_bits |= CASTLE_BQ;
      end
      PH_EP: begin
        if (c >= CH_LA && c <= CH_LH) ep_file = c - CH_LA;
        // a space here goes straight to the halfmove clock
        parse_ph = (c == CH_SPACE) ? PH_HALF : PH_SKIPSP;
      end
      PH_SKIPSP: if (c == CH_SPACE) parse_ph = PH_HALF;
      PH_HALF: begin
        if (is_dec(c)) half_clk = dec_accum(half_clk, c);
        else parse_ph = PH_FULL;
      end
      PH_FULL: begin
        if (is_dec(c)) begin
          full_num  = dec_accum(full_num, c);
          full_seen = 1'b1;
        end else begin
          parse_ph = PH_DONE;
        end
      end
      default: ;
    endcase

    if (r.last_char) begin
      for (int sq = 0; sq < BOARD_SQUARES; sq++) begin
        sq_res.square_index  = sq[5:0];
        sq_res.piece_code    = board_model[sq[5:0]];
        sq_res.black_to_play = side_bit;
        sq_res.castle_flags  = castle_bits;
        sq_res.ep_col        = ep_file;
        sq_res.half_moves    = half_clk;
        sq_res.move_no       = full_seen ? full_num : 16'd1;
        sq_res.last_square   = (sq[5:0] == SQ_LAST);
        board_expect_q.push_back(sq_res);
      end
      clear_parser();
    end
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus building: text_buf collects one string, queue_text turns it into
  // requests with last_char on the final byte
  // ---------------------------------------------------------------------------
  task automatic add_text(string s);
    for (int i = 0; i < s.len(); i++) text_buf.push_back(s[i]);
  endtask

  task automatic queue_text(bit hold);
    pend_t p;
    foreach (text_buf[i]) begin
      p.req.char_code = text_buf[i];
      p.req.last_char = (i == text_buf.size() - 1);
      p.hold          = hold && (i == 0);
      pending_q.push_back(p);
    end
    text_buf.delete();
  endtask

  function automatic logic [7:0] rand_byte_nospace();
    logic [7:0] b;
    b = 8'($urandom_range(0, 255));
    return (b == CH_SPACE) ? CH_LB + 8'd22 : b;
  endfunction

  task automatic add_digits(int n, bit big);
    int nd;
    nd = big ? $urandom_range(5, 6) : n;
    for (int i = 0; i < nd; i++)
      text_buf.push_back((big && i == 0) ? CH_0 + 8'($urandom_range(1, 9))
                                         : CH_0 + 8'($urandom_range(0, 9)));
  endtask

  // Mostly well-formed position strings with random content
  task automatic build_fen();
    string pieces;
    int    nranks, f, n, pick, keep;
    pieces = "pnbrqkPNBRQK";
    nranks = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 10) : 8;
    for (int r = 0; r < nranks; r++) begin
      f = 0;
      while (f < 8) begin
        pick = $urandom_range(0, 19);
        if (pick < 6) begin
          n = $urandom_range(1, 8 - f);
          if ($urandom_range(0, 15) == 0) n = $urandom_range(1, 8);
          text_buf.push_back(CH_0 + 8'(n));
          f += n;
        end else if (pick == 6) begin
          text_buf.push_back(rand_byte_nospace());
          f++;
        end else begin
          text_buf.push_back(pieces[$urandom_range(0, 11)]);
          f++;
        end
      end
      // occasionally run past the h-file
      if ($urandom_range(0, 9) == 0)
        repeat ($urandom_range(1, 10)) text_buf.push_back(pieces[$urandom_range(0, 11)]);
      if (r != nranks - 1) text_buf.push_back(CH_SLASH);
    end
    text_buf.push_back(CH_SPACE);

    pick = $urandom_range(0, 9);
    if (pick < 5)      text_buf.push_back(CH_LW);
    else if (pick < 9) text_buf.push_back(CH_LB);
    else               text_buf.push_back(8'($urandom_range(0, 255)));
    text_buf.push_back(CH_SPACE);

    n = 0;
    if ($urandom_range(0, 3) != 0) begin
      if ($urandom_range(0, 1)) begin text_buf.push_back(CH_UK); n++; end
      if ($urandom_range(0, 1)) begin text_buf.push_back(CH_UQ); n++; end
      if ($urandom_range(0, 1)) begin text_buf.push_back(CH_LK); n++; end
      if ($urandom_range(0, 1)) begin text_buf.push_back(CH_LQ); n++; end
      if ($urandom_range(0, 7) == 0) begin text_buf.push_back(rand_byte_nospace()); n++; end
    end
    if (n == 0) add_text("-");
    text_buf.push_back(CH_SPACE);

    pick = $urandom_range(0, 9);
    if (pick < 4) begin
      add_text("-");
    end else if (pick < 8) begin
      text_buf.push_back(CH_LA + 8'($urandom_range(0, 7)));
      add_text($urandom_range(0, 1) ? "3" : "6");
    end else if (pick == 8) begin
      text_buf.push_back(rand_byte_nospace());
    end
    // pick 9: no field, the space leads straight to the halfmove clock
    text_buf.push_back(CH_SPACE);

    add_digits(($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 3),
               $urandom_range(0, 7) == 0);
    text_buf.push_back(CH_SPACE);
    add_digits(($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 3),
               $urandom_range(0, 7) == 0);

    pick = $urandom_range(0, 9);
    if (pick >= 6 && pick < 8) begin
      // trailing characters after parsing is done
      repeat ($urandom_range(1, 3)) text_buf.push_back(8'($urandom_range(0, 255)));
    end else if (pick >= 8) begin
      // string cut short
      keep = $urandom_range(1, text_buf.size());
      while (text_buf.size() > keep) void'(text_buf.pop_back());
    end
  endtask

  initial begin
    clear_parser();

    // directed: top char code alone, ending the string at once
    text_buf.push_back(8'hFF);
    queue_text(1'b0);
    // every piece in both cases, a file past the h-file, a digit outside 1..8,
    // rank falling off the bottom, odd side char, junk in castling,
    // en passant skipped by a bare space, both counters saturating,
    // characters after the end of parsing and char code zero
    add_text("pnbrqkPNBRQK9/0////////p -xK-Qkq  65536 70000 w");
    text_buf.push_back(8'h00);
    queue_text(1'b0);
    // en passant file h with a trailing char, string ending mid-fullmove
    add_text("4k3 b xkq h4 12 34");
    queue_text(1'b0);
    // ends during placement, all header defaults
    add_text("7");
    queue_text(1'b0);

    // random part; the first random string waits for a fully drained block
    begin
      bit first_rand;
      first_rand = 1'b1;
      while (pending_q.size() < TARGET_ITEMS) begin
        if ($urandom_range(0, 4) == 0)
          repeat ($urandom_range(1, 12)) text_buf.push_back(8'($urandom_range(0, 255)));
        else
          build_fen();
        queue_text(first_rand || $urandom_range(0, 9) == 0);
        first_rand = 1'b0;
      end
    end

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_q.size() != 0 || push) @(posedge clk);
    while (board_expect_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (err_cnt == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Character driver: bursts of random length separated by random gaps.
  // A request stays up until it is taken.
  // ---------------------------------------------------------------------------
  int burst_left = 1;
  int gap_left = 0;

  always @(posedge clk) begin : char_drv
    logic drive_req;
    drive_req = 1'b0;
    if (!rst_n) begin
      push <= 1'b0;
    end else begin
      if (push && !full) begin
        fen_apply_char(in_data);
        void'(pending_q.pop_front());
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 24);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end
      end
      if (push && full) begin
        drive_req = 1'b1;
      end else if (pending_q.size() > 0) begin
        if (pending_q[0].hold && board_expect_q.size() != 0)
          drive_req = 1'b0;
        else if (gap_left > 0)
          gap_left--;
        else
          drive_req = 1'b1;
      end
      push <= drive_req;
      if (drive_req) in_data <= pending_q[0].req;
    end
  end

  // ---------------------------------------------------------------------------
  // Square monitor and pop stall pattern
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(string what, int sq, longint got, longint want);
    err_cnt++;
    if (err_cnt <= PRINT_CAP)
      $display("[%0t] square %0d %s: got %0d expected %0d", $realtime, sq, what, got, want);
  endtask

  logic [15:0] pop_pat = 16'hFFFF;
  logic [3:0]  pat_idx = '0;
  int          pat_left = 0;

  always @(posedge clk) begin : square_mon
    out_t want;
    if (!rst_n) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (board_expect_q.size() == 0) begin
          report_mismatch("unexpected request", out_data.square_index, 1, 0);
        end else begin
          want = board_expect_q.pop_front();
          if (out_data.square_index !== want.square_index)
            report_mismatch("square_index", want.square_index, out_data.square_index,
                            want.square_index);
          if (out_data.piece_code !== want.piece_code)
            report_mismatch("piece_code", want.square_index, out_data.piece_code,
                            want.piece_code);
          if (out_data.black_to_play !== want.black_to_play)
            report_mismatch("black_to_play", want.square_index, out_data.black_to_play,
                            want.black_to_play);
          if (out_data.castle_flags !== want.castle_flags)
            report_mismatch("castle_flags", want.square_index, out_data.castle_flags,
                            want.castle_flags);
          if (out_data.ep_col !== want.ep_col)
            report_mismatch("ep_col", want.square_index, out_data.ep_col,
                            want.ep_col);
          if (out_data.half_moves !== want.half_moves)
            report_mismatch("half_moves", want.square_index, out_data.half_moves,
                            want.half_moves);
          if (out_data.move_no !== want.move_no)
            report_mismatch("move_no", want.square_index, out_data.move_no,
                            want.move_no);
          if (out_data.last_square !== want.last_square)
            report_mismatch("last_square", want.square_index, out_data.last_square,
                            want.last_square);
        end
      end
      // new stall pattern now and then: none, random, sparse, long stalls
      if (pat_left <= 0) begin
        pat_left = $urandom_range(16, 200);
        case ($urandom_range(0, 3))
          0:       pop_pat = 16'hFFFF;
          1:       pop_pat = 16'($urandom);
          2:       pop_pat = 16'h0101;
          default: pop_pat = 16'h0001;
        endcase
      end
      pat_left--;
      pop <= pop_pat[pat_idx];
      pat_idx <= pat_idx + 4'd1;
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

endmodule

@@ sim.f @@
design/fpp_pkg.sv
design/fpp_front.sv
design/fpp_back.sv
design/fpp_outq.sv
design/fen_position_parser.sv
tb/sv/tb_top.sv
